### rtl/aopr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_pkg
// Shared types, constants and helpers for the box push-out resolver.
// ----------------------------------------------------------------------------
package aopr_pkg;

  // Signed fixed-point coordinate width (Q16.4)
  localparam int COORD_W = 20;
  // Unsigned box size width (Q12.4)
  localparam int SIZE_W  = 16;
  // Internal width: doubled coordinates plus size sums plus sign headroom
  localparam int EXT_W   = COORD_W + 6;

  // APB map: one 32-bit register per word
  localparam int APB_DW  = 32;
  localparam int REG_LSB = 2;
  localparam int ADDR_W  = 3;

  localparam int unsigned CFG_W_RESET = 480;
  localparam int unsigned CFG_H_RESET = 480;

  localparam logic signed [EXT_W-1:0] COORD_MAX =
    EXT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] COORD_MIN =
    EXT_W'(-(64'sd1 <<< (COORD_W - 1)));

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_BOX  = 1'b1
  } req_kind_e;

  typedef enum logic {
    REG_PLAYER_W = 1'b0,
    REG_PLAYER_H = 1'b1
  } reg_idx_e;

  typedef struct packed {
    req_kind_e                  req_type;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic        [SIZE_W-1:0]   box_width;
    logic        [SIZE_W-1:0]   box_height;
    logic signed [COORD_W-1:0]  speed_in;
    logic                       last_box;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  player_x;
    logic signed [COORD_W-1:0]  player_y;
    logic signed [COORD_W-1:0]  player_speed;
    logic                       landed;
    logic                       hit;
    logic                       pass_done;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] player_width;
    logic [SIZE_W-1:0] player_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] speed;
    logic                      landed;
  } state_t;

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [EXT_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/aopr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_req_if
// Request channel: valid/ready handshake carrying one load or box item.
// ----------------------------------------------------------------------------
interface aopr_req_if;
  import aopr_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/aopr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_rsp_if
// Result channel: valid/ready handshake carrying one resolved player state.
// ----------------------------------------------------------------------------
interface aopr_rsp_if;
  import aopr_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/aopr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_cfg_regs
// APB register file holding the player box size.
// ----------------------------------------------------------------------------
module aopr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aopr_pkg::ADDR_W-1:0]   paddr,
  input  logic [aopr_pkg::APB_DW-1:0]   pwdata,
  output logic [aopr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output aopr_pkg::cfg_t                cfg_o
);
  import aopr_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[REG_LSB]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PLAYER_W: cfg_d.player_width  = pwdata[SIZE_W-1:0];
        REG_PLAYER_H: cfg_d.player_height = pwdata[SIZE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PLAYER_W: prdata = APB_DW'(cfg_q.player_width);
      REG_PLAYER_H: prdata = APB_DW'(cfg_q.player_height);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_width  <= SIZE_W'(CFG_W_RESET);
      cfg_q.player_height <= SIZE_W'(CFG_H_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/aopr_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_resolve
// Load handling, overlap test and minimum-penetration push-out for one item.
// ----------------------------------------------------------------------------
module aopr_resolve (
  input  aopr_pkg::req_t   req_i,
  input  aopr_pkg::state_t cur_i,
  input  aopr_pkg::cfg_t   cfg_i,
  output aopr_pkg::state_t nxt_o,
  output logic             hit_o
);
  import aopr_pkg::*;

  logic signed [EXT_W-1:0] ix, iy, bw, bh, cx, cy, pw, ph;
  logic signed [EXT_W-1:0] dx2, dy2, adx, ady, px2, py2, dpx, dpy;
  logic signed [EXT_W-1:0] new_x, new_y;
  logic                    overlap;
  logic                    is_box;

  assign is_box = (req_i.req_type == REQ_BOX);

  assign ix = EXT_W'(req_i.pos_x);
  assign iy = EXT_W'(req_i.pos_y);
  assign bw = EXT_W'(req_i.box_width);
  assign bh = EXT_W'(req_i.box_height);
  assign cx = EXT_W'(cur_i.x);
  assign cy = EXT_W'(cur_i.y);
  assign pw = EXT_W'(cfg_i.player_width);
  assign ph = EXT_W'(cfg_i.player_height);

  // strict overlap: touching edges do not count
  assign overlap = (ix < cx + pw) && (ix + bw > cx) &&
                   (iy < cy + ph) && (iy + bh > cy);

  // centre offsets at doubled scale
  assign dx2 = (ix + ix + bw) - (cx + cx + pw);
  assign dy2 = (iy + iy + bh) - (cy + cy + ph);
  assign adx = (dx2 < 0) ? -dx2 : dx2;
  assign ady = (dy2 < 0) ? -dy2 : dy2;
  assign px2 = bw + pw - adx;
  assign py2 = bh + ph - ady;
  // depths are positive under overlap, so the shift rounds the half up
  assign dpx = (px2 + EXT_W'(1)) >>> 1;
  assign dpy = (py2 + EXT_W'(1)) >>> 1;

  assign new_x = (dx2 >= 0) ? cx - dpx : cx + dpx;
  assign new_y = (dy2 >= 0) ? cy - dpy : cy + dpy;

  always_comb begin
    nxt_o = cur_i;
    hit_o = 1'b0;
    if (!is_box) begin
      nxt_o.x      = req_i.pos_x;
      nxt_o.y      = req_i.pos_y;
      nxt_o.speed  = req_i.speed_in;
      nxt_o.landed = 1'b0;
    end else if (overlap) begin
      hit_o = 1'b1;
      if (px2 < py2) begin
        nxt_o.x = sat_coord(new_x);
      end else begin
        nxt_o.y     = sat_coord(new_y);
        nxt_o.speed = '0;
        if (dy2 > 0) begin
          nxt_o.landed = 1'b1;
        end
      end
    end
  end

endmodule

### rtl/aabb_push_out_resolver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_push_out_resolver_unit
// Player box vs. obstacle box collision, resolved by minimum penetration.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake            | content
//  ----------+-----+----------------------+--------------------------------
//  req_i     | in  | valid/ready          | load item or one obstacle box
//  rsp_o     | out | valid/ready          | player x, y, speed, flags
//  APB       | in  | psel/penable/pwrite  | player_width (0x0), height (0x4)
//
//  One item per cycle sustained while rsp_o.ready is high. Each item passes
//  the input register, then the result register. The carried player state
//  updates as an item leaves the input register, so the next item sees it.
//  A stalled result register holds; the input register then fills and
//  req_i.ready drops. Reset clears the handshake and player state and loads
//  the player size 480 (30.0 px) for both axes.
// ----------------------------------------------------------------------------
module aabb_push_out_resolver_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  aopr_req_if.sink                    req_i,
  aopr_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aopr_pkg::ADDR_W-1:0] paddr,
  input  logic [aopr_pkg::APB_DW-1:0] pwdata,
  output logic [aopr_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import aopr_pkg::*;

  cfg_t   cfg;

  // input register
  req_t   in_q;
  logic   in_valid_q;

  // carried player state
  state_t cur_q;
  state_t cur_d;

  // result register
  rsp_t   out_q;
  rsp_t   out_d;
  logic   out_valid_q;

  logic   res_hit;
  logic   advance;

  aopr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aopr_resolve u_resolve (
    .req_i (in_q),
    .cur_i (cur_q),
    .cfg_i (cfg),
    .nxt_o (cur_d),
    .hit_o (res_hit)
  );

  // item moves from the input register into the result register
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_comb begin
    out_d.player_x     = cur_d.x;
    out_d.player_y     = cur_d.y;
    out_d.player_speed = cur_d.speed;
    out_d.landed       = cur_d.landed;
    out_d.hit          = res_hit;
    out_d.pass_done    = (in_q.req_type == REQ_BOX) && in_q.last_box;
  end

  // payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cur_q       <= cur_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // a load always leaves landed clear
  a_load_clears_landed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.req_type == REQ_LOAD) |=> !cur_q.landed
  ) else $error("landed set after a load");

  // a box without a hit leaves the position alone
  a_miss_keeps_pos: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.req_type == REQ_BOX) && !res_hit |=>
      (cur_q.x == $past(cur_q.x)) && (cur_q.y == $past(cur_q.y))
  ) else $error("position moved without a hit");

  // landed only rises on a box that hit
  a_landed_needs_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(cur_q.landed) |-> $past(advance && res_hit)
  ) else $error("landed rose without a hit");

  // an empty input register never blocks the request side
  a_empty_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> req_i.ready
  ) else $error("request stalled with empty input register");

  // a stalled result is not dropped
  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q
  ) else $error("stalled result dropped");

endmodule

### tb/aopr_push_out_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopr_push_out_checker
// Watches request, result and APB traffic, predicts every resolved player
// state and compares it field by field in transfer order.
// ----------------------------------------------------------------------------
module aopr_push_out_checker
  import aopr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  aopr_req_if               req_mon,
  aopr_rsp_if               rsp_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_count
);

  cfg_t   size_cfg;
  state_t player_st;
  rsp_t   expected_moves[$];
  int     errors = 0;

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    longint top_v;
    top_v = (longint'(1) <<< (COORD_W - 1)) - 1;
    if (v > top_v) return COORD_W'(top_v);
    if (v < -top_v - 1) return COORD_W'(-top_v - 1);
    return COORD_W'(v);
  endfunction

  // Doubled-scale centres keep every depth an exact integer.
  function automatic rsp_t resolve_push_out(input req_t it);
    longint cx, cy, pw, ph, bx, by, bw, bh, dx2, dy2, px2, py2, step;
    rsp_t   r;
    r = '0;
    if (it.req_type == REQ_LOAD) begin
      player_st.x      = it.pos_x;
      player_st.y      = it.pos_y;
      player_st.speed  = it.speed_in;
      player_st.landed = 1'b0;
    end else begin
      cx = longint'(player_st.x);
      cy = longint'(player_st.y);
      pw = longint'(size_cfg.player_width);
      ph = longint'(size_cfg.player_height);
      bx = longint'(it.pos_x);
      by = longint'(it.pos_y);
      bw = longint'(it.box_width);
      bh = longint'(it.box_height);
      if (bx < cx + pw && bx + bw > cx && by < cy + ph && by + bh > cy) begin
        dx2 = (2 * bx + bw) - (2 * cx + pw);
        dy2 = (2 * by + bh) - (2 * cy + ph);
        px2 = bw + pw - (dx2 < 0 ? -dx2 : dx2);
        py2 = bh + ph - (dy2 < 0 ? -dy2 : dy2);
        r.hit = 1'b1;
        if (px2 < py2) begin
          step        = (px2 + 1) / 2;
          player_st.x = clamp_coord(dx2 >= 0 ? cx - step : cx + step);
        end else begin
          step = (py2 + 1) / 2;
          if (dy2 > 0) player_st.landed = 1'b1;
          player_st.y     = clamp_coord(dy2 >= 0 ? cy - step : cy + step);
          player_st.speed = '0;
        end
      end
      r.pass_done = it.last_box;
    end
    r.player_x     = player_st.x;
    r.player_y     = player_st.y;
    r.player_speed = player_st.speed;
    r.landed       = player_st.landed;
    return r;
  endfunction

  task automatic check_field(input string what, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      size_cfg.player_width  = SIZE_W'(CFG_W_RESET);
      size_cfg.player_height = SIZE_W'(CFG_H_RESET);
      player_st              = '0;
      expected_moves.delete();
      pending_count <= 0;
      fail_count    <= errors;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[REG_LSB]))
            REG_PLAYER_W: size_cfg.player_width  = pwdata[SIZE_W-1:0];
            REG_PLAYER_H: size_cfg.player_height = pwdata[SIZE_W-1:0];
          endcase
        end else begin
          case (reg_idx_e'(paddr[REG_LSB]))
            REG_PLAYER_W: check_field("player_width readback", size_cfg.player_width,
                                      prdata[SIZE_W-1:0]);
            REG_PLAYER_H: check_field("player_height readback", size_cfg.player_height,
                                      prdata[SIZE_W-1:0]);
          endcase
        end
      end

      if (req_mon.valid && req_mon.ready)
        expected_moves.push_back(resolve_push_out(req_mon.data));

      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (expected_moves.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual x %0d y %0d", $time,
                   got.player_x, got.player_y);
        end else begin
          want = expected_moves.pop_front();
          check_field("player_x", want.player_x, got.player_x);
          check_field("player_y", want.player_y, got.player_y);
          check_field("player_speed", want.player_speed, got.player_speed);
          check_field("landed", want.landed, got.landed);
          check_field("hit", want.hit, got.hit);
          check_field("pass_done", want.pass_done, got.pass_done);
        end
      end

      pending_count <= expected_moves.size();
      fail_count    <= errors;
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Box push-out resolver bench: directed corner items, then random passes
// (an optional load, then obstacle boxes around the player) and noise items
// under several player sizes; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import aopr_pkg::*;

  // Slowest run: ~1000 items with random idle gaps on each side plus the
  // two-stage pipe. The limit is far above that.
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_GAP      = 6;
  localparam int PHASE_ITEMS  = 165;
  localparam int N_PHASES     = 6;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending_count;
  int                cycles = 0;
  bit                calm;        // set: neither side idles for a while
  int                cur_w;       // player size as programmed, shapes the boxes
  int                cur_h;

  aopr_req_if req_ch ();
  aopr_rsp_if rsp_ch ();

  aabb_push_out_resolver_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  aopr_push_out_checker push_out_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Item builders. Load items leave the box fields zero; box items carry a
  // random speed that the block must ignore.
  // --------------------------------------------------------------------------
  function automatic req_t load_item(input int x, input int y, input int speed);
    req_t it;
    it          = '0;
    it.req_type = REQ_LOAD;
    it.pos_x    = COORD_W'(x);
    it.pos_y    = COORD_W'(y);
    it.speed_in = COORD_W'(speed);
    return it;
  endfunction

  function automatic req_t box_item(input int x, input int y, input int w, input int h,
                                    input bit last);
    req_t it;
    it            = '0;
    it.req_type   = REQ_BOX;
    it.pos_x      = COORD_W'(x);
    it.pos_y      = COORD_W'(y);
    it.box_width  = SIZE_W'(w);
    it.box_height = SIZE_W'(h);
    it.speed_in   = COORD_W'($urandom);
    it.last_box   = last;
    return it;
  endfunction

  // One request transfer, after a random idle gap. valid stays high across
  // back-to-back items so it never gets two assignments in one step.
  task automatic send_item(input req_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.data  <= it;
    req_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Setup then access phase. psel is left high so transfers can chain; the
  // caller drops psel/penable after the last one.
  task automatic apb_access(input bit is_write, input reg_idx_e idx,
                            input logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Stop sending and let every outstanding result come back. The first edge
  // lets the checker's count catch up with the last transfer; the tail covers
  // the two-stage pipe.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each transfer, none while calm.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    req_t it;
    int   sent;
    int   n_boxes;
    int   extra;
    int   ax;
    int   ay;
    int   bw;
    int   bh;
    int   ox;
    int   oy;

    rst_ni = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    calm  = 1'b0;
    cur_w = CFG_W_RESET;
    cur_h = CFG_H_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the size registers
    apb_access(1'b0, REG_PLAYER_W, '0);
    apb_access(1'b0, REG_PLAYER_H, '0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // ---- directed corners, player 480 x 480 ----
    send_item(load_item(0, 0, -37));
    send_item(box_item(480, 0, 100, 100, 1'b0));     // touches right edge only
    send_item(box_item(0, 480, 480, 480, 1'b0));     // touches bottom edge only
    send_item(box_item(470, 0, 100, 480, 1'b0));     // shallow on x: push left
    send_item(box_item(-600, 470, 2000, 480, 1'b0)); // floor below: land
    send_item(box_item(-600, -475, 2000, 480, 1'b1));// ceiling above, ends pass
    send_item(load_item(1000, 1000, 55));
    send_item(box_item(1000, 1000, 480, 480, 1'b0)); // same box: equal depth, level
    send_item(load_item(0, 0, 9));
    send_item(box_item(-470, 0, 480, 480, 1'b0));    // wall on the left: push right
    send_item(box_item(101, 0, 481, 480, 1'b0));     // odd sizes
    send_item(load_item(int'(COORD_MIN), 0, int'(COORD_MIN)));
    send_item(box_item(int'(COORD_MIN) + 200, 0, 480, 480, 1'b0)); // clamps at min x
    send_item(load_item(0, int'(COORD_MAX), int'(COORD_MAX)));
    send_item(box_item(0, int'(COORD_MAX) - 400, 480, 480, 1'b1)); // clamps at max y
    send_item(load_item(0, 0, 3));
    send_item(box_item(100, 100, 0, 0, 1'b0));       // zero-size box inside player
    send_item(box_item(-1, -1, 65535, 65535, 1'b0)); // largest box
    send_item(box_item(int'(COORD_MIN), int'(COORD_MIN), 65535, 65535, 1'b1));
    send_item(box_item(int'(COORD_MAX), int'(COORD_MAX), 0, 0, 1'b0));
    send_item(load_item(-100, -200, int'(COORD_MAX)));
    send_item(box_item(-100, 180, 480, 480, 1'b1));  // land, ends pass
    send_item(box_item(-100, 180, 480, 480, 1'b0));  // after the last box: still resolves
    it = load_item(5, 5, 0);
    it.last_box = 1'b1;                              // load never reports pass_done
    send_item(it);
    send_item(box_item(5, 5, 480, 480, 1'b0));
    drain();

    // ---- random passes under a range of player sizes ----
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin cur_w = 480;   cur_h = 480;   end
        1: begin cur_w = 0;     cur_h = 0;     end
        2: begin cur_w = 65535; cur_h = 65535; end
        3: begin cur_w = 1;     cur_h = 65535; end
        4: begin cur_w = 65535; cur_h = 7;     end
        default: begin
          cur_w = $urandom_range(0, 2047);
          cur_h = $urandom_range(0, 2047);
        end
      endcase
      apb_access(1'b1, REG_PLAYER_W, SIZE_W'(cur_w));
      apb_access(1'b1, REG_PLAYER_H, SIZE_W'(cur_h));
      apb_access(1'b0, REG_PLAYER_W, '0);
      apb_access(1'b0, REG_PLAYER_H, '0);
      psel    <= 1'b0;
      penable <= 1'b0;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) begin
          // noise: any kind, every field over its full range
          it.req_type   = req_kind_e'($urandom_range(0, 1));
          it.pos_x      = COORD_W'($urandom);
          it.pos_y      = COORD_W'($urandom);
          it.box_width  = SIZE_W'($urandom);
          it.box_height = SIZE_W'($urandom);
          it.speed_in   = COORD_W'($urandom);
          it.last_box   = 1'($urandom_range(0, 1));
          send_item(it);
          sent++;
        end else begin
          // a pass: load near an anchor, then boxes scattered around the
          // player so that touches, grazes and deep overlaps all show up
          if ($urandom_range(0, 9) == 0) begin
            ax = $urandom;
            ay = $urandom;
          end else begin
            ax = $urandom_range(0, 400000) - 200000;
            ay = $urandom_range(0, 400000) - 200000;
          end
          // now and then skip the load so the pass runs on carried state
          if ($urandom_range(0, 9) != 0) begin
            send_item(load_item(ax, ay, $urandom));
            sent++;
          end
          n_boxes = $urandom_range(1, 8);
          extra   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
          for (int i = 0; i < n_boxes + extra; i++) begin
            bw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
            bh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
            ox = $urandom_range(0, bw + cur_w + 64) - bw - 32;
            oy = $urandom_range(0, bh + cur_h + 64) - bh - 32;
            send_item(box_item(ax + ox, ay + oy, bw, bh, i == n_boxes - 1));
            sent++;
          end
        end
      end
      calm = 1'b0;
      drain();
    end

    // Final verdict
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
